### rtl/rrss_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the production store step unit
// no dependencies

package rrss_pkg;

  localparam int FRAC_BITS = 16;

  localparam int IN_W   = 26;
  localparam int OUT_W  = 30;
  localparam int SUB_W  = 17;
  localparam int STAT_W = 2;
  localparam int CIDX_W = 2;

  // divider geometry: dividend bits, divisor bits
  localparam int DIV_NW = 92;
  localparam int DIV_DW = 56;
  localparam int DIV_CW = 7;

  typedef logic [IN_W-1:0]   in_val_t;
  typedef logic [OUT_W-1:0]  out_val_t;
  typedef logic [SUB_W-1:0]  sub_t;
  typedef logic [STAT_W-1:0] stat_t;
  typedef logic [CIDX_W-1:0] cidx_t;
  typedef logic [60:0]       acc_t;

  // status codes
  localparam stat_t STAT_OK       = 2'd0;
  localparam stat_t STAT_BAD_SUB  = 2'd1;
  localparam stat_t STAT_BAD_CAP  = 2'd2;
  localparam stat_t STAT_BAD_INIT = 2'd3;

  // register indexes
  localparam cidx_t REG_CAPACITY = 2'd0;
  localparam cidx_t REG_SUBSTEPS = 2'd1;
  localparam cidx_t REG_INIT_LVL = 2'd2;

  localparam logic [63:0] QONE    = 64'd1 << 30;
  localparam logic [31:0] E_INV_Q = 32'd395007542;
  localparam logic [60:0] ACC_CAP = 61'd1 << 60;
  localparam sub_t        SUB_MAX = 17'd100000;
  localparam logic [29:0] CAP_LO  = 30'd5 << FRAC_BITS;
  localparam logic [29:0] CAP_HI  = 30'd10000 << FRAC_BITS;
  localparam logic [3:0]  SERIES_TERMS = 4'd14;

  localparam logic [29:0] RST_CAPACITY = 30'd350 << FRAC_BITS;
  localparam sub_t        RST_SUBSTEPS = 17'd1;
  localparam logic [29:0] RST_INIT_LVL = 30'd175 << FRAC_BITS;

  function automatic acc_t sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > 64'(ACC_CAP)) ? ACC_CAP : s[60:0];
  endfunction

  function automatic out_val_t out_sat(input acc_t v);
    logic [44:0] w;
    w = v[60:16];
    return (w > 45'h3FFF_FFFF) ? 30'h3FFF_FFFF : w[29:0];
  endfunction

endpackage

### rtl/rrss_in_if.sv
`timescale 1ns / 1ps
// input channel of the production store step unit
// depends on rrss_pkg

interface rrss_in_if;
  import rrss_pkg::*;

  logic    valid;
  logic    ready;
  logic    first_step;
  in_val_t rainfall;
  in_val_t evaporation;

  modport source (output valid, first_step, rainfall, evaporation, input ready);
  modport sink   (input valid, first_step, rainfall, evaporation, output ready);
endinterface

### rtl/rrss_out_if.sv
`timescale 1ns / 1ps
// result channel of the production store step unit
// depends on rrss_pkg

interface rrss_out_if;
  import rrss_pkg::*;

  logic     valid;
  logic     ready;
  stat_t    status;
  out_val_t store_out;
  out_val_t infiltration;
  out_val_t store_evap;
  out_val_t percolation;
  out_val_t effective_rain;
  out_val_t actual_evap;

  modport source (output valid, status, store_out, infiltration, store_evap, percolation,
                  effective_rain, actual_evap, input ready);
  modport sink   (input valid, status, store_out, infiltration, store_evap, percolation,
                  effective_rain, actual_evap, output ready);
endinterface

### rtl/rrss_mul.sv
`timescale 1ns / 1ps
// q30 fixed point multiply floor(a*b/2^30), one 32x32 multiplier used twice
// depends on rrss_pkg

module rrss_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] res
);
  import rrss_pkg::*;

  logic [1:0]  ph_r, ph_nxt;
  logic [63:0] a_r;
  logic [31:0] b_r;
  logic [63:0] lo_r, hi_r, res_r;
  logic        done_r;
  logic [31:0] mop;
  logic [63:0] prod;

  assign mop  = (ph_r == 2'd1) ? a_r[31:0] : a_r[63:32];
  assign prod = 64'(mop) * 64'(b_r);

  always_comb begin
    ph_nxt = ph_r;
    if (start) begin
      ph_nxt = 2'd1;
    end else if (ph_r != 2'd0) begin
      ph_nxt = (ph_r == 2'd3) ? 2'd0 : ph_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= 2'd0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= (ph_r == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (ph_r == 2'd1) lo_r <= prod;
    if (ph_r == 2'd2) hi_r <= prod;
    if (ph_r == 2'd3) res_r <= (hi_r << 2) + (lo_r >> 30);
  end

  assign done = done_r;
  assign res  = res_r;
endmodule

### rtl/rrss_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle over the whole dividend
// depends on rrss_pkg

module rrss_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [rrss_pkg::DIV_NW-1:0] num,
  input  logic [rrss_pkg::DIV_DW-1:0] den,
  output logic                     done,
  output logic [63:0]              quo
);
  import rrss_pkg::*;

  logic [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0] den_r, rem_r;
  logic [63:0]       quo_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [DIV_DW:0]   trial, diff;
  logic              qbit;

  assign trial = {rem_r, num_r[DIV_NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign qbit  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= DIV_CW'(DIV_NW - 1);
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NW-2:0], 1'b0};
      rem_r <= qbit ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      quo_r <= {quo_r[62:0], qbit};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

### rtl/rrss_sqrt.sv
`timescale 1ns / 1ps
// integer square root by shift and subtract, working from the top radicand bits down
// depends on rrss_pkg

module rrss_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] v,
  output logic        done,
  output logic [31:0] root
);
  import rrss_pkg::*;

  logic [63:0] v_r, r_r, bit_r, rb;
  logic        busy_r, done_r;
  logic        take;

  assign rb   = r_r + bit_r;
  assign take = (v_r >= rb);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && bit_r[0];
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= v;
      r_r   <= '0;
      bit_r <= 64'd1 << 62;
    end else if (busy_r) begin
      v_r   <= take ? v_r - rb : v_r;
      r_r   <= take ? (r_r >> 1) + bit_r : (r_r >> 1);
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];
endmodule

### rtl/rainfall_runoff_store_step_unit.sv
`timescale 1ns / 1ps
// production store step: sequencer over a shared divider, multiplier and square root
// the step setup forms pi or ei and the tanh argument, then tanh(x) by series or via exp(-2x);
//   each substep forms the fill fraction, infiltration or store evaporation, then a fourth root
// throughput: one transaction at a time, in_if.ready only while idle; a bad configuration
//   answers in the next cycle; the divider's one bit per cycle sets the pace
// reset: synchronous active low, store level cleared, registers to their defaults

module rainfall_runoff_store_step_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  rrss_in_if.sink              in_if,
  rrss_out_if.source           out_if,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_idx,
  input  logic [29:0]          cfg_data
);
  import rrss_pkg::*;

  // sequencer states
  localparam logic [5:0] ST_IDLE   = 6'd0;
  localparam logic [5:0] ST_PI     = 6'd1;
  localparam logic [5:0] ST_TQ     = 6'd2;
  localparam logic [5:0] ST_TQN1   = 6'd3;
  localparam logic [5:0] ST_TQN2   = 6'd4;
  localparam logic [5:0] ST_TS_MUL = 6'd5;
  localparam logic [5:0] ST_TS_DIV = 6'd6;
  localparam logic [5:0] ST_TS_OM  = 6'd7;
  localparam logic [5:0] ST_TS_TH  = 6'd8;
  localparam logic [5:0] ST_TS_G   = 6'd9;
  localparam logic [5:0] ST_EX_MUL = 6'd10;
  localparam logic [5:0] ST_EX_DIV = 6'd11;
  localparam logic [5:0] ST_EX_K   = 6'd12;
  localparam logic [5:0] ST_TH     = 6'd13;
  localparam logic [5:0] ST_GR     = 6'd14;
  localparam logic [5:0] ST_MN     = 6'd15;
  localparam logic [5:0] ST_SR     = 6'd16;
  localparam logic [5:0] ST_PA     = 6'd17;
  localparam logic [5:0] ST_PB     = 6'd18;
  localparam logic [5:0] ST_PC     = 6'd19;
  localparam logic [5:0] ST_PD     = 6'd20;
  localparam logic [5:0] ST_PE     = 6'd21;
  localparam logic [5:0] ST_EA     = 6'd22;
  localparam logic [5:0] ST_EB     = 6'd23;
  localparam logic [5:0] ST_EC     = 6'd24;
  localparam logic [5:0] ST_ED     = 6'd25;
  localparam logic [5:0] ST_EE     = 6'd26;
  localparam logic [5:0] ST_ACC    = 6'd27;
  localparam logic [5:0] ST_ACC2   = 6'd28;
  localparam logic [5:0] ST_Q      = 6'd29;
  localparam logic [5:0] ST_Q2     = 6'd30;
  localparam logic [5:0] ST_Q3     = 6'd31;
  localparam logic [5:0] ST_QN     = 6'd32;
  localparam logic [5:0] ST_R1     = 6'd33;
  localparam logic [5:0] ST_R2     = 6'd34;
  localparam logic [5:0] ST_S2     = 6'd35;
  localparam logic [5:0] ST_PCA    = 6'd36;
  localparam logic [5:0] ST_FIN    = 6'd37;
  localparam logic [5:0] ST_OUT    = 6'd38;

  // shared unit selection
  localparam logic [1:0] U_NONE = 2'd0;
  localparam logic [1:0] U_DIV  = 2'd1;
  localparam logic [1:0] U_MUL  = 2'd2;
  localparam logic [1:0] U_SQRT = 2'd3;

  // control state
  logic [5:0]  state_r, state_nxt;
  logic        wait_r, wait_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [31:0] level_r, level_nxt;
  logic [29:0] cap_r, cap_nxt;
  sub_t        sub_r, sub_nxt;
  logic [29:0] init_r, init_nxt;

  // working registers of the step
  sub_t        n_r, n_nxt, j_r, j_nxt;
  logic [45:0] x1_r, x1_nxt;
  logic [49:0] x9_r, x9_nxt;
  in_val_t     dd_r, dd_nxt, pmin_r, pmin_nxt;
  logic        rain_r, rain_nxt;
  acc_t        s_r, s_nxt;
  logic [41:0] pi_r, pi_nxt, ei_r, ei_nxt, mn_r, mn_nxt;
  logic [55:0] xv_r, xv_nxt;
  logic [63:0] t_r, t_nxt, h_r, h_nxt, m_r, m_nxt, c_r, c_nxt;
  logic [30:0] ev_r, ev_nxt, th_r, th_nxt, g_r, g_nxt, sr_r, sr_nxt;
  logic [30:0] a_r, a_nxt, q_r, q_nxt;
  logic [3:0]  i_r, i_nxt;
  logic [4:0]  k_r, k_nxt;
  logic [42:0] psi_r, psi_nxt, esi_r, esi_nxt;
  logic [31:0] rt_r, rt_nxt;
  acc_t        ps_r, ps_nxt, es_r, es_nxt, pc_r, pc_nxt, pr_r, pr_nxt, ae_r, ae_nxt;

  // result registers
  stat_t    ost_r, ost_nxt;
  out_val_t oso_r, oso_nxt, oin_r, oin_nxt, oev_r, oev_nxt;
  out_val_t opc_r, opc_nxt, oef_r, oef_nxt, oae_r, oae_nxt;

  // shared unit ports
  logic [1:0]        u_sel;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [63:0]       mul_a, mul_res, div_quo, sq_v;
  logic [31:0]       mul_b, sq_root;
  logic              div_done, mul_done, sq_done, u_done;
  logic              ratio_full, launch, adv;
  logic [63:0]       rq;

  // helper values
  logic [56:0] y;
  logic [31:0] qe, qc;
  logic [62:0] s4;
  logic        in_acc, cfg_bad;
  stat_t       chk;

  assign y  = {xv_r, 1'b0};
  assign qe = 32'(QONE) + {1'b0, ev_r};
  assign qc = 32'(QONE) + c_r[31:0];
  assign s4 = {s_r, 2'b00};

  // configuration check, in order substeps, capacity, initial level
  always_comb begin
    chk = STAT_OK;
    if (sub_r < 17'd1 || sub_r > SUB_MAX) begin
      chk = STAT_BAD_SUB;
    end else if (cap_r < CAP_LO || cap_r > CAP_HI) begin
      chk = STAT_BAD_CAP;
    end else if (init_r < 30'd1 || init_r > cap_r - 30'd1) begin
      chk = STAT_BAD_INIT;
    end
  end
  assign cfg_bad = (chk != STAT_OK);

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;

  // operand selection for the shared units
  always_comb begin
    u_sel      = U_NONE;
    div_num    = '0;
    div_den    = '0;
    mul_a      = '0;
    mul_b      = '0;
    sq_v       = '0;
    ratio_full = 1'b0;
    unique case (state_r)
      ST_PI: begin
        u_sel = U_DIV; div_num = {50'd0, dd_r, 16'd0}; div_den = {39'd0, n_r};
      end
      ST_TQ: begin
        u_sel = U_DIV; div_num = {36'd0, dd_r, 30'd0}; div_den = {26'd0, cap_r};
      end
      ST_TQN1, ST_TQN2: begin
        u_sel = U_DIV; div_num = {36'd0, xv_r}; div_den = {39'd0, n_r};
      end
      ST_TS_MUL: begin
        u_sel = U_MUL; mul_a = t_r; mul_b = y[31:0];
      end
      ST_TS_DIV: begin
        u_sel = U_DIV; div_num = {28'd0, t_r}; div_den = {51'd0, {1'b0, i_r} + 5'd1};
      end
      ST_TS_OM: begin
        u_sel = U_MUL; mul_a = {7'd0, y}; mul_b = h_r[31:0];
      end
      ST_TS_TH: begin
        u_sel = U_DIV; div_num = {t_r[61:0], 30'd0}; div_den = {24'd0, qe};
      end
      ST_TS_G: begin
        u_sel = U_DIV; div_num = {h_r[60:0], 1'b0, 30'd0}; div_den = {24'd0, qe};
      end
      ST_EX_MUL: begin
        u_sel = U_MUL; mul_a = t_r; mul_b = {2'd0, y[29:0]};
      end
      ST_EX_DIV: begin
        u_sel = U_DIV; div_num = {28'd0, t_r}; div_den = {52'd0, i_r};
      end
      ST_EX_K: begin
        u_sel = U_MUL; mul_a = h_r; mul_b = E_INV_Q;
      end
      ST_TH: begin
        u_sel = U_DIV; div_num = {31'd0, QONE[30:0] - ev_r, 30'd0}; div_den = {24'd0, qe};
      end
      ST_GR: begin
        u_sel      = U_DIV;
        ratio_full = ({25'd0, th_r} >= xv_r);
        div_num    = {31'd0, th_r, 30'd0};
        div_den    = xv_r;
      end
      ST_MN: begin
        u_sel = U_DIV; div_num = {50'd0, pmin_r, 16'd0}; div_den = {39'd0, n_r};
      end
      ST_SR: begin
        u_sel      = U_DIV;
        ratio_full = (s_r >= {15'd0, x1_r});
        div_num    = {1'b0, s_r, 30'd0};
        div_den    = {10'd0, x1_r};
      end
      ST_PA: begin
        u_sel = U_MUL; mul_a = {33'd0, sr_r}; mul_b = {1'b0, sr_r};
      end
      ST_PB: begin
        u_sel = U_MUL; mul_a = {22'd0, pi_r}; mul_b = {1'b0, a_r};
      end
      ST_PC, ST_EC: begin
        u_sel = U_MUL; mul_a = m_r; mul_b = {1'b0, g_r};
      end
      ST_PD: begin
        u_sel = U_MUL; mul_a = {33'd0, sr_r}; mul_b = {1'b0, th_r};
      end
      ST_PE, ST_EE: begin
        u_sel = U_DIV; div_num = {m_r[61:0], 30'd0}; div_den = {24'd0, qc};
      end
      ST_EA: begin
        u_sel = U_MUL; mul_a = {22'd0, ei_r}; mul_b = {1'b0, sr_r};
      end
      ST_EB: begin
        u_sel = U_MUL; mul_a = m_r; mul_b = 32'h8000_0000 - {1'b0, sr_r};
      end
      ST_ED: begin
        u_sel = U_MUL; mul_a = {33'd0, QONE[30:0] - sr_r}; mul_b = {1'b0, th_r};
      end
      ST_Q: begin
        u_sel      = U_DIV;
        ratio_full = (s4 >= {13'd0, x9_r});
        div_num    = {s4[61:0], 30'd0};
        div_den    = {6'd0, x9_r};
      end
      ST_Q2, ST_Q3: begin
        u_sel = U_MUL; mul_a = {33'd0, q_r}; mul_b = {1'b0, q_r};
      end
      ST_QN: begin
        u_sel = U_DIV; div_num = {61'd0, q_r}; div_den = {39'd0, n_r};
      end
      ST_R1: begin
        u_sel = U_SQRT; sq_v = {t_r[33:0], 30'd0};
      end
      ST_R2: begin
        u_sel = U_SQRT; sq_v = {2'd0, rt_r, 30'd0};
      end
      ST_S2: begin
        u_sel = U_DIV; div_num = {1'b0, s_r, 30'd0}; div_den = {24'd0, rt_r};
      end
      default: begin
        u_sel = U_NONE;
      end
    endcase
  end

  // a ratio at or above one skips the divider
  assign launch = (u_sel != U_NONE) && !wait_r && !ratio_full;
  assign u_done = div_done || mul_done || sq_done;
  assign adv    = wait_r ? u_done : ratio_full;
  assign rq     = ratio_full ? QONE : div_quo;

  rrss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (launch && (u_sel == U_DIV)),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  rrss_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (launch && (u_sel == U_MUL)),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  rrss_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (launch && (u_sel == U_SQRT)),
    .v     (sq_v),
    .done  (sq_done),
    .root  (sq_root)
  );

  // sequencer
  always_comb begin
    logic [63:0] hn;
    logic [41:0] psc;
    acc_t        sa, dsub;
    logic [44:0] sl;

    state_nxt = state_r;   wait_nxt = wait_r;   ovalid_nxt = ovalid_r;
    level_nxt = level_r;   cap_nxt = cap_r;     sub_nxt = sub_r;     init_nxt = init_r;
    n_nxt = n_r;   j_nxt = j_r;   x1_nxt = x1_r;   x9_nxt = x9_r;
    dd_nxt = dd_r; pmin_nxt = pmin_r; rain_nxt = rain_r; s_nxt = s_r;
    pi_nxt = pi_r; ei_nxt = ei_r; mn_nxt = mn_r; xv_nxt = xv_r;
    t_nxt = t_r;   h_nxt = h_r;   m_nxt = m_r;   c_nxt = c_r;
    ev_nxt = ev_r; th_nxt = th_r; g_nxt = g_r;   sr_nxt = sr_r;
    a_nxt = a_r;   q_nxt = q_r;   i_nxt = i_r;   k_nxt = k_r;
    psi_nxt = psi_r; esi_nxt = esi_r; rt_nxt = rt_r;
    ps_nxt = ps_r; es_nxt = es_r; pc_nxt = pc_r; pr_nxt = pr_r; ae_nxt = ae_r;
    ost_nxt = ost_r; oso_nxt = oso_r; oin_nxt = oin_r; oev_nxt = oev_r;
    opc_nxt = opc_r; oef_nxt = oef_r; oae_nxt = oae_r;

    hn   = i_r[0] ? h_r - div_quo : h_r + div_quo;
    psc  = (div_quo > {22'd0, pi_r}) ? pi_r : div_quo[41:0];
    sa   = s_r;
    dsub = s_r - c_r[60:0];
    sl   = s_r[60:16];

    if (cfg_we) begin
      case (cfg_idx)
        REG_CAPACITY: cap_nxt  = cfg_data;
        REG_SUBSTEPS: sub_nxt  = cfg_data[SUB_W-1:0];
        REG_INIT_LVL: init_nxt = cfg_data;
        default: ;
      endcase
    end

    if (launch) wait_nxt = 1'b1;
    if (wait_r && u_done) wait_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (cfg_bad) begin
            ost_nxt = chk;
            oso_nxt = '0; oin_nxt = '0; oev_nxt = '0;
            opc_nxt = '0; oef_nxt = '0; oae_nxt = '0;
            ovalid_nxt = 1'b1;
            state_nxt  = ST_OUT;
          end else begin
            n_nxt    = sub_r;
            x1_nxt   = {cap_r, 16'd0};
            x9_nxt   = {1'b0, cap_r, 19'd0} + {4'd0, cap_r, 16'd0};
            s_nxt    = in_if.first_step ? {15'd0, init_r, 16'd0} : {13'd0, level_r, 16'd0};
            rain_nxt = (in_if.rainfall > in_if.evaporation);
            dd_nxt   = (in_if.rainfall > in_if.evaporation) ?
                       in_if.rainfall - in_if.evaporation :
                       in_if.evaporation - in_if.rainfall;
            pmin_nxt = (in_if.rainfall < in_if.evaporation) ?
                       in_if.rainfall : in_if.evaporation;
            pi_nxt = '0; ei_nxt = '0; th_nxt = '0; g_nxt = '0;
            ps_nxt = '0; es_nxt = '0; pc_nxt = '0; pr_nxt = '0; ae_nxt = '0;
            state_nxt = (in_if.rainfall != in_if.evaporation) ? ST_PI : ST_MN;
          end
        end
      end
      ST_PI: if (adv) begin
        if (rain_r) pi_nxt = div_quo[41:0];
        else        ei_nxt = div_quo[41:0];
        state_nxt = ST_TQ;
      end
      ST_TQ: if (adv) begin
        xv_nxt = div_quo[55:0]; state_nxt = ST_TQN1;
      end
      ST_TQN1: if (adv) begin
        xv_nxt = div_quo[55:0]; state_nxt = ST_TQN2;
      end
      ST_TQN2: if (adv) begin
        xv_nxt = div_quo[55:0];
        t_nxt  = QONE;
        h_nxt  = QONE;
        i_nxt  = 4'd1;
        k_nxt  = div_quo[33:29];
        // small argument: series of (1 - e^-2x)/2x, otherwise through exp(-2x)
        if (div_quo[55:29] == '0) begin
          state_nxt = ST_TS_MUL;
        end else if (div_quo[55:29] >= 27'd22) begin
          ev_nxt    = '0;
          state_nxt = ST_TH;
        end else begin
          state_nxt = ST_EX_MUL;
        end
      end
      ST_TS_MUL: if (adv) begin
        t_nxt = mul_res; state_nxt = ST_TS_DIV;
      end
      ST_TS_DIV: if (adv) begin
        t_nxt = div_quo;
        h_nxt = hn;
        if (i_r == SERIES_TERMS) begin
          state_nxt = ST_TS_OM;
        end else begin
          i_nxt     = i_r + 4'd1;
          state_nxt = ST_TS_MUL;
        end
      end
      ST_TS_OM: if (adv) begin
        t_nxt  = mul_res;
        ev_nxt = QONE[30:0] - mul_res[30:0];
        state_nxt = ST_TS_TH;
      end
      ST_TS_TH: if (adv) begin
        th_nxt = div_quo[30:0]; state_nxt = ST_TS_G;
      end
      ST_TS_G: if (adv) begin
        g_nxt = (div_quo > QONE) ? QONE[30:0] : div_quo[30:0];
        state_nxt = ST_MN;
      end
      ST_EX_MUL: if (adv) begin
        t_nxt = mul_res; state_nxt = ST_EX_DIV;
      end
      ST_EX_DIV: if (adv) begin
        t_nxt = div_quo;
        h_nxt = hn;
        if (i_r == SERIES_TERMS) begin
          if (k_r == 5'd0) begin
            ev_nxt    = hn[30:0];
            state_nxt = ST_TH;
          end else begin
            state_nxt = ST_EX_K;
          end
        end else begin
          i_nxt     = i_r + 4'd1;
          state_nxt = ST_EX_MUL;
        end
      end
      ST_EX_K: if (adv) begin
        // one factor of 1/e for each integer unit
        h_nxt = mul_res;
        k_nxt = k_r - 5'd1;
        if (k_r == 5'd1) begin
          ev_nxt    = mul_res[30:0];
          state_nxt = ST_TH;
        end
      end
      ST_TH: if (adv) begin
        th_nxt = div_quo[30:0]; state_nxt = ST_GR;
      end
      ST_GR: if (adv) begin
        g_nxt = (rq > QONE) ? QONE[30:0] : rq[30:0];
        state_nxt = ST_MN;
      end
      ST_MN: if (adv) begin
        mn_nxt = div_quo[41:0];
        j_nxt  = '0;
        state_nxt = ST_SR;
      end
      ST_SR: if (adv) begin
        sr_nxt  = rq[30:0];
        psi_nxt = '0;
        esi_nxt = '0;
        state_nxt = (pi_r != '0) ? ST_PA : ((ei_r != '0) ? ST_EA : ST_ACC);
      end
      ST_PA: if (adv) begin
        a_nxt = QONE[30:0] - mul_res[30:0]; state_nxt = ST_PB;
      end
      ST_PB: if (adv) begin
        m_nxt = mul_res; state_nxt = ST_PC;
      end
      ST_PC: if (adv) begin
        m_nxt = mul_res; state_nxt = ST_PD;
      end
      ST_PD: if (adv) begin
        c_nxt = mul_res; state_nxt = ST_PE;
      end
      ST_PE: if (adv) begin
        psi_nxt   = {1'b0, psc};
        state_nxt = (ei_r != '0) ? ST_EA : ST_ACC;
      end
      ST_EA: if (adv) begin
        m_nxt = mul_res; state_nxt = ST_EB;
      end
      ST_EB: if (adv) begin
        m_nxt = mul_res; state_nxt = ST_EC;
      end
      ST_EC: if (adv) begin
        m_nxt = mul_res; state_nxt = ST_ED;
      end
      ST_ED: if (adv) begin
        c_nxt = mul_res; state_nxt = ST_EE;
      end
      ST_EE: if (adv) begin
        esi_nxt = div_quo[42:0]; state_nxt = ST_ACC;
      end
      ST_ACC: begin
        ps_nxt = sat_add(64'(ps_r), 64'(psi_r));
        pr_nxt = sat_add(64'(pr_r), 64'(pi_r) - 64'(psi_r));
        es_nxt = sat_add(64'(es_r), 64'(esi_r));
        ae_nxt = sat_add(64'(ae_r), 64'(sat_add(64'(esi_r), 64'(mn_r))));
        s_nxt  = sat_add(64'(s_r), 64'(psi_r));
        state_nxt = ST_ACC2;
      end
      ST_ACC2: begin
        sa    = (s_r > 61'(esi_r)) ? s_r - 61'(esi_r) : '0;
        s_nxt = sa;
        state_nxt = ST_Q;
      end
      ST_Q: if (adv) begin
        q_nxt = rq[30:0]; state_nxt = ST_Q2;
      end
      ST_Q2: if (adv) begin
        q_nxt = mul_res[30:0]; state_nxt = ST_Q3;
      end
      ST_Q3: if (adv) begin
        q_nxt = mul_res[30:0]; state_nxt = ST_QN;
      end
      ST_QN: if (adv) begin
        t_nxt = QONE + div_quo; state_nxt = ST_R1;
      end
      ST_R1: if (adv) begin
        rt_nxt = sq_root; state_nxt = ST_R2;
      end
      ST_R2: if (adv) begin
        rt_nxt = sq_root; state_nxt = ST_S2;
      end
      ST_S2: if (adv) begin
        c_nxt = (div_quo > 64'(s_r)) ? 64'(s_r) : div_quo;
        state_nxt = ST_PCA;
      end
      ST_PCA: begin
        pc_nxt = sat_add(64'(pc_r), 64'(dsub));
        pr_nxt = sat_add(64'(pr_r), 64'(dsub));
        s_nxt  = c_r[60:0];
        j_nxt  = j_r + 1'b1;
        state_nxt = (j_r + 1'b1 == n_r) ? ST_FIN : ST_SR;
      end
      ST_FIN: begin
        level_nxt = (sl > 45'hFFFF_FFFF) ? 32'hFFFF_FFFF : sl[31:0];
        ost_nxt = STAT_OK;
        oso_nxt = out_sat(s_r);
        oin_nxt = out_sat(ps_r);
        oev_nxt = out_sat(es_r);
        opc_nxt = out_sat(pc_r);
        oef_nxt = out_sat(pr_r);
        oae_nxt = out_sat(ae_r);
        ovalid_nxt = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (out_if.ready) begin
          ovalid_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wait_r   <= 1'b0;
      ovalid_r <= 1'b0;
      level_r  <= '0;
      cap_r    <= RST_CAPACITY;
      sub_r    <= RST_SUBSTEPS;
      init_r   <= RST_INIT_LVL;
    end else begin
      state_r  <= state_nxt;
      wait_r   <= wait_nxt;
      ovalid_r <= ovalid_nxt;
      level_r  <= level_nxt;
      cap_r    <= cap_nxt;
      sub_r    <= sub_nxt;
      init_r   <= init_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    n_r <= n_nxt;   j_r <= j_nxt;   x1_r <= x1_nxt;   x9_r <= x9_nxt;
    dd_r <= dd_nxt; pmin_r <= pmin_nxt; rain_r <= rain_nxt; s_r <= s_nxt;
    pi_r <= pi_nxt; ei_r <= ei_nxt; mn_r <= mn_nxt; xv_r <= xv_nxt;
    t_r <= t_nxt;   h_r <= h_nxt;   m_r <= m_nxt;   c_r <= c_nxt;
    ev_r <= ev_nxt; th_r <= th_nxt; g_r <= g_nxt;   sr_r <= sr_nxt;
    a_r <= a_nxt;   q_r <= q_nxt;   i_r <= i_nxt;   k_r <= k_nxt;
    psi_r <= psi_nxt; esi_r <= esi_nxt; rt_r <= rt_nxt;
    ps_r <= ps_nxt; es_r <= es_nxt; pc_r <= pc_nxt; pr_r <= pr_nxt; ae_r <= ae_nxt;
    ost_r <= ost_nxt; oso_r <= oso_nxt; oin_r <= oin_nxt; oev_r <= oev_nxt;
    opc_r <= opc_nxt; oef_r <= oef_nxt; oae_r <= oae_nxt;
  end

  assign out_if.valid          = ovalid_r;
  assign out_if.status         = ost_r;
  assign out_if.store_out      = oso_r;
  assign out_if.infiltration   = oin_r;
  assign out_if.store_evap     = oev_r;
  assign out_if.percolation    = opc_r;
  assign out_if.effective_rain = oef_r;
  assign out_if.actual_evap    = oae_r;

  // a pending result never overlaps taking a new transaction
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready |-> !out_if.valid) else $error("ready while a result is pending");

  // only one shared unit answers at a time, and only when awaited
  a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({div_done, mul_done, sq_done})) else $error("two units finished together");

  a_done_awaited: assert property (@(posedge clk) disable iff (!rst_n)
    u_done |-> wait_r) else $error("unit finished with nothing waiting");

  // a bad configuration answers on the next cycle with an error status
  a_bad_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cfg_bad) |=> (out_if.valid && out_if.status != STAT_OK))
    else $error("bad configuration not reported");

  // substep counter stays inside the configured count
  a_substep_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SR) |-> (j_r < n_r)) else $error("substep counter overran");
endmodule

### bench/tb_rainfall_runoff_store_step_unit.sv
`timescale 1ns / 1ps
// self-checking bench for rainfall_runoff_store_step_unit: directed table then random phases
// depends on rrss_pkg, rrss_in_if, rrss_out_if and the unit itself

module tb_rainfall_runoff_store_step_unit;
  import rrss_pkg::*;

  // one result transaction, field for field
  typedef struct {
    stat_t    status;
    out_val_t store_out;
    out_val_t infiltration;
    out_val_t store_evap;
    out_val_t percolation;
    out_val_t effective_rain;
    out_val_t actual_evap;
  } step_result_t;

  // one row of the directed table: a register write or a step
  typedef struct {
    bit          is_write;
    cidx_t       idx;
    logic [29:0] data;
    bit          first;
    in_val_t     rain;
    in_val_t     evap;
    bit          typed;      // expected result written in the row
    stat_t       typed_stat; // all other fields are then zero
  } table_row_t;

  typedef longint unsigned u64;

  localparam u64 Q_ONE     = 64'd1 << 30;
  localparam u64 E_INV     = 64'd395007542;
  localparam u64 SUM_CAP   = 64'd1 << 60;
  localparam u64 FIELD_MAX = 64'h3FFF_FFFF;
  localparam u64 LVL_MAX   = 64'hFFFF_FFFF;
  localparam u64 MM        = 64'd1 << FRAC_BITS;
  localparam int GUARD     = 16;
  localparam int TERMS     = 14;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [29:0] cfg_data;

  rrss_in_if  in_ch ();
  rrss_out_if out_ch ();

  rainfall_runoff_store_step_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // mirror of the registers and of the store level
  u64 m_capacity;
  u64 m_substeps;
  u64 m_initial;
  u64 m_level;

  step_result_t expected_steps[$];
  table_row_t   steps_table[$];

  int  n_steps_sent;
  int  n_results;
  int  n_fail;
  int  n_bad_cfg;
  int  n_phases;
  bit  calm;       // no idling on either side while set
  bit  sink_held;  // the long receiver hold-off has happened

  // ---------------------------------------------------------------------------
  // fixed-point helpers of the predictor
  // ---------------------------------------------------------------------------

  // floor(a*b / 2^30)
  function automatic u64 fx_mul(u64 a, u64 b);
    u64 hi;
    u64 lo;
    hi = a >> 32;
    lo = a & 64'hFFFF_FFFF;
    return ((hi * b) << 2) + ((lo * b) >> 30);
  endfunction

  // floor(m * 2^30 / d)
  function automatic u64 fx_div(u64 m, u64 d);
    u64 q;
    u64 r;
    q = m / d;
    r = m % d;
    return (q << 30) + ((r << 30) / d);
  endfunction

  // fill fraction, clipped at one
  function automatic u64 fill_frac(u64 num, u64 den);
    u64 r;
    u64 q;
    r = num;
    q = 0;
    if (num >= den) return Q_ONE;
    for (int i = 0; i < 30; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic u64 int_sqrt(u64 v);
    u64 r;
    u64 b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // e^-y, y in Q34.30
  function automatic u64 exp_decay(u64 y);
    u64 k;
    u64 f;
    u64 acc;
    u64 t;
    k = y >> 30;
    f = y & (Q_ONE - 1);
    acc = Q_ONE;
    t = Q_ONE;
    if (k >= 22) return 0;
    for (int i = 1; i <= TERMS; i++) begin
      t = fx_mul(t, f) / u64'(i);
      if (i % 2 == 1) acc = acc - t;
      else acc = acc + t;
    end
    for (u64 j = 0; j < k; j++) acc = fx_mul(acc, E_INV);
    return acc;
  endfunction

  // tanh(x) and tanh(x)/x, both Q2.30
  function automatic void tanh_and_gain(input u64 x, output u64 th, output u64 g);
    u64 y;
    u64 t;
    u64 h;
    u64 om;
    u64 ev;
    y = x << 1;
    if (y < Q_ONE) begin
      // series of (1 - e^-2x) / 2x
      t = Q_ONE;
      h = Q_ONE;
      for (int i = 1; i <= TERMS; i++) begin
        t = fx_mul(t, y) / u64'(i + 1);
        if (i % 2 == 1) h = h - t;
        else h = h + t;
      end
      om = fx_mul(y, h);
      ev = Q_ONE - om;
      th = fx_div(om, Q_ONE + ev);
      g  = fx_div(h << 1, Q_ONE + ev);
    end else begin
      ev = exp_decay(y);
      th = fx_div(Q_ONE - ev, Q_ONE + ev);
      g  = fill_frac(th, x);
    end
    if (g > Q_ONE) g = Q_ONE;
  endfunction

  function automatic u64 add_sat(u64 a, u64 b);
    u64 s;
    s = a + b;
    return (s > SUM_CAP) ? SUM_CAP : s;
  endfunction

  function automatic out_val_t to_field(u64 v);
    return (v > FIELD_MAX) ? out_val_t'(FIELD_MAX) : out_val_t'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // predictor: one time step of the production store
  // ---------------------------------------------------------------------------
  function automatic step_result_t store_step(bit first, u64 p, u64 e);
    step_result_t res;
    u64 n, x1, s, pi, ei, th, g, mn, d;
    u64 ps, es, pc, pr, ae;
    u64 sr, psi, esi, q, v, rt, s2, a, t;
    res = '{default: '0};
    pi = 0; ei = 0; th = 0; g = 0;
    ps = 0; es = 0; pc = 0; pr = 0; ae = 0;

    // configuration checks in fixed order, state untouched on failure
    if (m_substeps < 1 || m_substeps > 100000) begin
      res.status = STAT_BAD_SUB;
      return res;
    end
    if (m_capacity < u64'(CAP_LO) || m_capacity > u64'(CAP_HI)) begin
      res.status = STAT_BAD_CAP;
      return res;
    end
    if (m_initial < 1 || m_initial > m_capacity - 1) begin
      res.status = STAT_BAD_INIT;
      return res;
    end

    n  = m_substeps;
    x1 = m_capacity << GUARD;
    if (first) m_level = m_initial;
    s = m_level << GUARD;

    // net rain or net evaporation, tanh argument scaled by 1/n twice
    if (p > e) begin
      d  = p - e;
      pi = (d << GUARD) / n;
      tanh_and_gain(((d << 30) / m_capacity) / n / n, th, g);
    end else if (e > p) begin
      d  = e - p;
      ei = (d << GUARD) / n;
      tanh_and_gain(((d << 30) / m_capacity) / n / n, th, g);
    end
    mn = (((p < e) ? p : e) << GUARD) / n;

    for (u64 j = 0; j < n; j++) begin
      sr = fill_frac(s, x1);
      psi = 0;
      esi = 0;
      if (pi != 0) begin
        a   = Q_ONE - fx_mul(sr, sr);
        psi = fx_div(fx_mul(fx_mul(pi, a), g), Q_ONE + fx_mul(sr, th));
        if (psi > pi) psi = pi;
      end
      if (ei != 0) begin
        t   = fx_mul(fx_mul(ei, sr), 2 * Q_ONE - sr);
        esi = fx_div(fx_mul(t, g), Q_ONE + fx_mul(Q_ONE - sr, th));
      end
      ps = add_sat(ps, psi);
      pr = add_sat(pr, pi - psi);
      es = add_sat(es, esi);
      ae = add_sat(ae, add_sat(esi, mn));
      s  = add_sat(s, psi);
      s  = (s > esi) ? s - esi : 0;

      // percolation through a fourth root
      q  = fill_frac(s << 2, 9 * x1);
      q  = fx_mul(q, q);
      q  = fx_mul(q, q);
      v  = Q_ONE + q / n;
      rt = int_sqrt(int_sqrt(v << 30) << 30);
      s2 = fx_div(s, rt);
      if (s2 > s) s2 = s;
      pc = add_sat(pc, s - s2);
      pr = add_sat(pr, s - s2);
      s  = s2;
    end

    s = s >> GUARD;
    m_level = (s > LVL_MAX) ? LVL_MAX : s;
    res.status         = STAT_OK;
    res.store_out      = to_field(s);
    res.infiltration   = to_field(ps >> GUARD);
    res.store_evap     = to_field(es >> GUARD);
    res.percolation    = to_field(pc >> GUARD);
    res.effective_rain = to_field(pr >> GUARD);
    res.actual_evap    = to_field(ae >> GUARD);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------------------

  // register write, only once the unit has drained
  task automatic write_reg(cidx_t idx, logic [29:0] value);
    wait (expected_steps.size() == 0);
    repeat (20) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CAPACITY: m_capacity = u64'(value);
      REG_SUBSTEPS: m_substeps = u64'(value[SUB_W-1:0]);
      REG_INIT_LVL: m_initial  = u64'(value);
      default: ;
    endcase
  endtask

  // offer one step and wait for the input handshake
  task automatic send_step(bit first, in_val_t rain, in_val_t evap,
                           bit typed, stat_t typed_stat);
    step_result_t pred;
    while (!calm && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.first_step  <= first;
    in_ch.rainfall    <= rain;
    in_ch.evaporation <= evap;
    do @(posedge clk); while (!in_ch.ready);
    pred = store_step(first, u64'(rain), u64'(evap));
    if (typed) begin
      pred = '{default: '0};
      pred.status = typed_stat;
    end
    if (pred.status != STAT_OK) n_bad_cfg++;
    expected_steps.push_back(pred);
    n_steps_sent++;
  endtask

  function automatic in_val_t pick_flux();
    case ($urandom_range(9))
      0: return '0;
      1: return in_val_t'($urandom);
      2: return in_val_t'($urandom_range(65536000));
      3: return in_val_t'($urandom_range(65536000, 67108863));
      default: return in_val_t'($urandom_range(30 * 65536));
    endcase
  endfunction

  function automatic void add_write(cidx_t idx, logic [29:0] value);
    table_row_t r;
    r = '{default: '0};
    r.is_write = 1'b1;
    r.idx = idx;
    r.data = value;
    steps_table.push_back(r);
  endfunction

  function automatic void add_step(bit first, in_val_t rain, in_val_t evap,
                                   bit typed, stat_t st);
    table_row_t r;
    r = '{default: '0};
    r.first = first;
    r.rain = rain;
    r.evap = evap;
    r.typed = typed;
    r.typed_stat = st;
    steps_table.push_back(r);
  endfunction

  // one random setting of all three registers, valid or deliberately broken
  task automatic new_setting(output bit broken);
    u64 cap;
    u64 sub;
    u64 init;
    int kind;
    broken = ($urandom_range(9) == 0);
    kind = $urandom_range(2);
    case ($urandom_range(9))
      0: cap = u64'(CAP_LO);
      1: cap = u64'(CAP_HI);
      default: cap = ($urandom_range(5, 9999) * MM) + $urandom_range(65535);
    endcase
    if ($urandom_range(99) < 70) sub = $urandom_range(1, 3);
    else sub = $urandom_range(4, 12);
    case ($urandom_range(7))
      0: init = 1;
      1: init = cap - 1;
      default: init = $urandom_range(1, 32'(cap - 1));
    endcase
    if (broken) begin
      if (kind == 0) begin
        sub = ($urandom_range(1) == 0) ? 0 : $urandom_range(100001, 131071);
      end else if (kind == 1) begin
        sub = ($urandom_range(1) == 0) ? 100000 : sub;
        cap = ($urandom_range(1) == 0) ? $urandom_range(32'(CAP_LO) - 1)
                                       : $urandom_range(32'(CAP_HI) + 1, 32'h3FFF_FFFF);
      end else begin
        init = ($urandom_range(1) == 0) ? 0 : $urandom_range(32'(cap), 32'h3FFF_FFFF);
      end
    end
    write_reg(REG_CAPACITY, 30'(cap));
    write_reg(REG_SUBSTEPS, 30'(sub));
    write_reg(REG_INIT_LVL, 30'(init));
    n_phases++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready with random stalls, one long hold-off, checking
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold;
    step_result_t want;
    u64 got_w[7];
    u64 want_w[7];
    string names[7];
    names = '{"status", "store_out", "infiltration", "store_evap",
              "percolation", "effective_rain", "actual_evap"};
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_steps.size() == 0) begin
          $display("%0t: result transaction with nothing expected", $realtime);
          n_fail++;
        end else begin
          want = expected_steps.pop_front();
          got_w  = '{out_ch.status, out_ch.store_out, out_ch.infiltration,
                     out_ch.store_evap, out_ch.percolation,
                     out_ch.effective_rain, out_ch.actual_evap};
          want_w = '{want.status, want.store_out, want.infiltration, want.store_evap,
                     want.percolation, want.effective_rain, want.actual_evap};
          for (int f = 0; f < 7; f++) begin
            if (got_w[f] !== want_w[f]) begin
              $display("%0t: result %0d %s expected %0d actual %0d", $realtime,
                       n_results, names[f], want_w[f], got_w[f]);
              n_fail++;
            end
          end
        end
        // long hold-off so the unit fills up and stalls its input
        if (n_results == 150 && !sink_held) begin
          sink_held = 1'b1;
          hold = 6000;
        end
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 38);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    bit broken;
    int per_phase;
    int rand_steps;
    table_row_t row;
    in_val_t rain_max;
    rain_max = '1;

    n_steps_sent = 0; n_results = 0; n_fail = 0; n_bad_cfg = 0; n_phases = 0;
    calm = 1'b0; sink_held = 1'b0;
    m_capacity = u64'(RST_CAPACITY);
    m_substeps = u64'(RST_SUBSTEPS);
    m_initial  = u64'(RST_INIT_LVL);
    m_level    = 0;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= '0;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.first_step  <= 1'b0;
    in_ch.rainfall    <= '0;
    in_ch.evaporation <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // series never started: empty store and no flux gives all zero
    add_step(0, '0, '0, 1, STAT_OK);
    add_step(1, 26'(10 * MM), 26'(2 * MM), 0, STAT_OK);
    add_step(0, 26'(2 * MM), 26'(10 * MM), 0, STAT_OK);
    // equal rain and evaporation
    add_step(0, 26'(5 * MM), 26'(5 * MM), 0, STAT_OK);
    add_step(0, rain_max, '0, 0, STAT_OK);
    // evaporation far beyond the store empties it
    add_step(0, '0, rain_max, 0, STAT_OK);
    // widest store filled, then shrunk so the level sits above capacity
    add_write(REG_CAPACITY, CAP_HI);
    add_write(REG_INIT_LVL, CAP_HI - 30'd1);
    add_step(1, rain_max, '0, 0, STAT_OK);
    add_write(REG_CAPACITY, CAP_LO);
    add_write(REG_INIT_LVL, 30'd1);
    add_step(0, 26'(1 * MM), '0, 0, STAT_OK);
    add_step(1, '0, '0, 0, STAT_OK);
    // configuration errors, checked substeps first
    add_write(REG_SUBSTEPS, 30'd0);
    add_step(1, 26'(3 * MM), '0, 1, STAT_BAD_SUB);
    add_write(REG_SUBSTEPS, 30'd131071);
    add_step(0, '0, 26'(3 * MM), 1, STAT_BAD_SUB);
    add_write(REG_SUBSTEPS, 30'd100000);
    add_write(REG_CAPACITY, 30'd0);
    add_step(1, '0, '0, 1, STAT_BAD_CAP);
    add_write(REG_CAPACITY, 30'h3FFF_FFFF);
    add_step(0, rain_max, rain_max, 1, STAT_BAD_CAP);
    add_write(REG_SUBSTEPS, 30'd4);
    add_write(REG_CAPACITY, RST_CAPACITY);
    add_write(REG_INIT_LVL, 30'd0);
    add_step(1, 26'(4 * MM), '0, 1, STAT_BAD_INIT);
    add_write(REG_INIT_LVL, RST_CAPACITY);
    add_step(1, 26'(4 * MM), '0, 1, STAT_BAD_INIT);
    add_write(REG_INIT_LVL, RST_CAPACITY - 30'd1);
    add_step(1, 26'(20 * MM), 26'(1 * MM), 0, STAT_OK);
    add_step(0, 26'(1 * MM), 26'(6 * MM), 0, STAT_OK);

    foreach (steps_table[i]) begin
      row = steps_table[i];
      if (row.is_write) begin
        in_ch.valid <= 1'b0;
        write_reg(row.idx, row.data);
      end else begin
        send_step(row.first, row.rain, row.evap, row.typed, row.typed_stat);
      end
    end

    // random phases, each behind a fresh register setting
    rand_steps = 0;
    while (rand_steps < 1250) begin
      in_ch.valid <= 1'b0;
      new_setting(broken);
      per_phase = broken ? 8 : $urandom_range(40, 80);
      for (int k = 0; k < per_phase; k++) begin
        calm = (rand_steps >= 600 && rand_steps < 800);
        send_step(k == 0 || $urandom_range(14) == 0, pick_flux(), pick_flux(), 0, STAT_OK);
        rand_steps++;
      end
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    wait (expected_steps.size() == 0);
    repeat (3000) @(posedge clk);

    $display("%0d step transactions in %0d register settings, %0d with a configuration error",
             n_steps_sent, n_phases, n_bad_cfg);
    $display("%0d result transactions checked, %0d mismatches", n_results, n_fail);
    if (n_fail == 0 && expected_steps.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin : watchdog
    #500ms;
    $display("%0t: timeout with %0d results outstanding", $realtime, expected_steps.size());
    $display("simulation failed");
    $finish;
  end

endmodule

### rainfall_runoff_store_step_unit.f
rtl/rrss_pkg.sv
rtl/rrss_in_if.sv
rtl/rrss_out_if.sv
rtl/rrss_mul.sv
rtl/rrss_div.sv
rtl/rrss_sqrt.sv
rtl/rainfall_runoff_store_step_unit.sv
bench/tb_rainfall_runoff_store_step_unit.sv
